### rtl/scta_pkg.sv
// Shared types, constants and scancode translation tables for the scancode FIFO.
package scta_pkg;

  localparam int unsigned FIFO_DEPTH_DEF = 256;
  localparam int unsigned KEY_W          = 7;
  localparam int unsigned CHAR_W         = 7;
  localparam int unsigned NUM_KEYS       = 128;

  localparam logic [KEY_W-1:0]  KEY_LSHIFT = 7'h2A;
  localparam logic [KEY_W-1:0]  KEY_RSHIFT = 7'h36;
  localparam logic [KEY_W-1:0]  KEY_CAPS   = 7'h3A;
  localparam logic [CHAR_W-1:0] CASE_GAP   = 7'h20;
  localparam logic [CHAR_W-1:0] LOWER_A    = 7'h61;
  localparam logic [CHAR_W-1:0] LOWER_Z    = 7'h7A;

  typedef enum logic {
    OP_SCAN = 1'b0,
    OP_POP  = 1'b1
  } op_e;

  // Character handed from the key decoder to the FIFO.
  typedef struct packed {
    logic              valid;
    logic [CHAR_W-1:0] ch;
  } push_t;

  function automatic logic [CHAR_W-1:0] plain_char(input logic [KEY_W-1:0] key);
    logic [CHAR_W-1:0] c;
    case (key)
      7'd1:  c = 7'h1B;
      7'd2:  c = 7'h31;
      7'd3:  c = 7'h32;
      7'd4:  c = 7'h33;
      7'd5:  c = 7'h34;
      7'd6:  c = 7'h35;
      7'd7:  c = 7'h36;
      7'd8:  c = 7'h37;
      7'd9:  c = 7'h38;
      7'd10: c = 7'h39;
      7'd11: c = 7'h30;
      7'd12: c = 7'h2D;
      7'd13: c = 7'h3D;
      7'd14: c = 7'h08;
      7'd15: c = 7'h09;
      7'd16: c = 7'h71;
      7'd17: c = 7'h77;
      7'd18: c = 7'h65;
      7'd19: c = 7'h72;
      7'd20: c = 7'h74;
      7'd21: c = 7'h79;
      7'd22: c = 7'h75;
      7'd23: c = 7'h69;
      7'd24: c = 7'h6F;
      7'd25: c = 7'h70;
      7'd26: c = 7'h5B;
      7'd27: c = 7'h5D;
      7'd28: c = 7'h0A;
      7'd30: c = 7'h61;
      7'd31: c = 7'h73;
      7'd32: c = 7'h64;
      7'd33: c = 7'h66;
      7'd34: c = 7'h67;
      7'd35: c = 7'h68;
      7'd36: c = 7'h6A;
      7'd37: c = 7'h6B;
      7'd38: c = 7'h6C;
      7'd39: c = 7'h3B;
      7'd40: c = 7'h27;
      7'd41: c = 7'h60;
      7'd43: c = 7'h5C;
      7'd44: c = 7'h7A;
      7'd45: c = 7'h78;
      7'd46: c = 7'h63;
      7'd47: c = 7'h76;
      7'd48: c = 7'h62;
      7'd49: c = 7'h6E;
      7'd50: c = 7'h6D;
      7'd51: c = 7'h2C;
      7'd52: c = 7'h2E;
      7'd53: c = 7'h2F;
      7'd55: c = 7'h2A;
      7'd57: c = 7'h20;
      default: c = '0;
    endcase
    return c;
  endfunction

  function automatic logic [CHAR_W-1:0] shift_char(input logic [KEY_W-1:0] key);
    logic [CHAR_W-1:0] c;
    case (key)
      7'd1:  c = 7'h1B;
      7'd2:  c = 7'h21;
      7'd3:  c = 7'h40;
      7'd4:  c = 7'h23;
      7'd5:  c = 7'h24;
      7'd6:  c = 7'h25;
      7'd7:  c = 7'h5E;
      7'd8:  c = 7'h26;
      7'd9:  c = 7'h2A;
      7'd10: c = 7'h28;
      7'd11: c = 7'h29;
      7'd12: c = 7'h5F;
      7'd13: c = 7'h2B;
      7'd14: c = 7'h08;
      7'd15: c = 7'h09;
      7'd16: c = 7'h51;
      7'd17: c = 7'h57;
      7'd18: c = 7'h45;
      7'd19: c = 7'h52;
      7'd20: c = 7'h54;
      7'd21: c = 7'h59;
      7'd22: c = 7'h55;
      7'd23: c = 7'h49;
      7'd24: c = 7'h4F;
      7'd25: c = 7'h50;
      7'd26: c = 7'h7B;
      7'd27: c = 7'h7D;
      7'd28: c = 7'h0A;
      7'd30: c = 7'h41;
      7'd31: c = 7'h53;
      7'd32: c = 7'h44;
      7'd33: c = 7'h46;
      7'd34: c = 7'h47;
      7'd35: c = 7'h48;
      7'd36: c = 7'h4A;
      7'd37: c = 7'h4B;
      7'd38: c = 7'h4C;
      7'd39: c = 7'h3A;
      7'd40: c = 7'h22;
      7'd41: c = 7'h7E;
      7'd43: c = 7'h7C;
      7'd44: c = 7'h5A;
      7'd45: c = 7'h58;
      7'd46: c = 7'h43;
      7'd47: c = 7'h56;
      7'd48: c = 7'h42;
      7'd49: c = 7'h4E;
      7'd50: c = 7'h4D;
      7'd51: c = 7'h3C;
      7'd52: c = 7'h3E;
      7'd53: c = 7'h3F;
      7'd55: c = 7'h2A;
      7'd57: c = 7'h20;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

### rtl/scta_keymap.sv
// Key state tracking and scancode to character translation.
module scta_keymap (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        scan_fire_i,
  input  logic [7:0]                  scan_byte_i,
  output scta_pkg::push_t             push_o
);

  logic [scta_pkg::NUM_KEYS-1:0] held_q, held_d;
  logic                          shift_q, shift_d;
  logic                          caps_q, caps_d;

  logic [scta_pkg::KEY_W-1:0]  key;
  logic                        release_key;
  logic                        is_shift;
  logic [scta_pkg::CHAR_W-1:0] raw_ch;
  logic [scta_pkg::CHAR_W-1:0] ch;

  assign key         = scan_byte_i[6:0];
  assign release_key = scan_byte_i[7];
  assign is_shift    = (key == scta_pkg::KEY_LSHIFT) || (key == scta_pkg::KEY_RSHIFT);

  assign raw_ch = shift_q ? scta_pkg::shift_char(key) : scta_pkg::plain_char(key);

  always_comb begin
    ch = raw_ch;
    if (caps_q && raw_ch >= scta_pkg::LOWER_A && raw_ch <= scta_pkg::LOWER_Z) begin
      ch = raw_ch - scta_pkg::CASE_GAP;
    end
  end

  always_comb begin
    held_d       = held_q;
    shift_d      = shift_q;
    caps_d       = caps_q;
    push_o.valid = 1'b0;
    push_o.ch    = ch;
    if (scan_fire_i) begin
      if (release_key) begin
        held_d[key] = 1'b0;
        if (is_shift) begin
          shift_d = 1'b0;
        end
      end else if (!held_q[key]) begin
        // A press of a key that is already down is typematic repeat and is dropped.
        held_d[key] = 1'b1;
        if (is_shift) begin
          shift_d = 1'b1;
        end else if (key == scta_pkg::KEY_CAPS) begin
          caps_d = ~caps_q;
        end else begin
          push_o.valid = (ch != '0);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q  <= '0;
      shift_q <= 1'b0;
      caps_q  <= 1'b0;
    end else begin
      held_q  <= held_d;
      shift_q <= shift_d;
      caps_q  <= caps_d;
    end
  end

`ifndef SYNTHESIS
  a_shift_release_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (scan_fire_i && release_key && is_shift) |=> !shift_q)
    else $error("shift flag survived a shift key release");

  a_repeat_no_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (scan_fire_i && !release_key && held_q[key]) |-> !push_o.valid)
    else $error("typematic repeat pushed a character");
`endif

endmodule

### rtl/scta_char_fifo.sv
// Ring buffer of translated characters with a registered pop result.
module scta_char_fifo #(
  parameter int unsigned FIFO_DEPTH = scta_pkg::FIFO_DEPTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  scta_pkg::push_t             push_i,
  input  logic                        pop_fire_i,
  input  logic                        out_stall_i,
  output logic                        out_valid_o,
  output logic                        char_valid_o,
  output logic [scta_pkg::CHAR_W-1:0] ascii_char_o
);

  localparam int unsigned PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

  logic [scta_pkg::CHAR_W-1:0] mem_q [FIFO_DEPTH];
  logic [scta_pkg::CHAR_W-1:0] rd_data_q;

  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [PTR_W-1:0] wr_next, rd_next;
  logic             out_valid_q, out_valid_d;
  logic             char_valid_q, char_valid_d;
  logic             empty, full, push_ok;

  assign wr_next = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
  assign rd_next = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
  assign empty   = (wr_ptr_q == rd_ptr_q);
  // One slot always stays free, so a full ring drops the new character.
  assign full    = (wr_next == rd_ptr_q);
  assign push_ok = push_i.valid && !full;

  always_comb begin
    wr_ptr_d     = push_ok ? wr_next : wr_ptr_q;
    rd_ptr_d     = (pop_fire_i && !empty) ? rd_next : rd_ptr_q;
    out_valid_d  = out_valid_q && out_stall_i;
    char_valid_d = char_valid_q;
    if (pop_fire_i) begin
      out_valid_d  = 1'b1;
      char_valid_d = !empty;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[wr_ptr_q] <= push_i.ch;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_fire_i) begin
      rd_data_q <= mem_q[rd_ptr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q     <= '0;
      rd_ptr_q     <= '0;
      out_valid_q  <= 1'b0;
      char_valid_q <= 1'b0;
    end else begin
      wr_ptr_q     <= wr_ptr_d;
      rd_ptr_q     <= rd_ptr_d;
      out_valid_q  <= out_valid_d;
      char_valid_q <= char_valid_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign char_valid_o = out_valid_q && char_valid_q;
  assign ascii_char_o = char_valid_o ? rd_data_q : '0;

`ifndef SYNTHESIS
  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_ptr_q <= PTR_LAST) && (rd_ptr_q <= PTR_LAST))
    else $error("ring pointer out of range");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !pop_fire_i)
    else $error("pop taken while a result is still held");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_fire_i && !empty) |=> (out_valid_o && char_valid_o))
    else $error("pop of a non-empty ring returned no character");
`endif

endmodule

### rtl/scancode_to_ascii_fifo.sv
// Scancode translator top level: key decoder feeding a character ring buffer.
// One item may be accepted in every cycle while in_stall_o is low.
// A pop word appears at the output register in the cycle after acceptance.
// Scancode words are never stalled; a pop is stalled only while a previous
// pop word is held at the output and the receiver stalls it.
// Reset clears held keys, shift and caps flags, and both ring pointers at once.
module scancode_to_ascii_fifo #(
  parameter int unsigned FIFO_DEPTH = scta_pkg::FIFO_DEPTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        operation_i,
  input  logic [7:0]                  scan_byte_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        char_valid_o,
  output logic [scta_pkg::CHAR_W-1:0] ascii_char_o
);

  scta_pkg::push_t push;
  logic            is_pop;
  logic            scan_fire;
  logic            pop_fire;

  assign is_pop     = (operation_i == scta_pkg::OP_POP);
  assign in_stall_o = is_pop && out_valid_o && out_stall_i;
  assign scan_fire  = in_valid_i && !is_pop;
  assign pop_fire   = in_valid_i && is_pop && !in_stall_o;

  scta_keymap u_keymap (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .scan_fire_i (scan_fire),
    .scan_byte_i (scan_byte_i),
    .push_o      (push)
  );

  scta_char_fifo #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_char_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .pop_fire_i   (pop_fire),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .char_valid_o (char_valid_o),
    .ascii_char_o (ascii_char_o)
  );

endmodule
